// ----- sv/xml_stream_tokenizer_assert.svh -----
// Assertion macros shared by the tokenizer modules.
`ifndef XML_STREAM_TOKENIZER_ASSERT_SVH
`define XML_STREAM_TOKENIZER_ASSERT_SVH

`ifndef SYNTH

// Property must hold at every rising clock edge outside reset.
`define XST_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("tokenizer assertion failed");

// Condition must never be seen at a rising clock edge outside reset.
`define XST_ASSERT_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("tokenizer forbidden condition seen");

`else

`define XST_ASSERT(lbl, clk, rst_n, prop)
`define XST_ASSERT_NEVER(lbl, clk, rst_n, cond)

`endif

`endif

// ----- sv/xst_pkg.sv -----
package xst_pkg;

    // Output depth field width
    localparam int DEPTH_W = 6;

    // Event codes
    localparam logic [3:0] EV_TEXT  = 4'd0;
    localparam logic [3:0] EV_NAME  = 4'd1;
    localparam logic [3:0] EV_OPEN  = 4'd2;
    localparam logic [3:0] EV_CLOSE = 4'd3;
    localparam logic [3:0] EV_ANAME = 4'd4;
    localparam logic [3:0] EV_AVAL  = 4'd5;
    localparam logic [3:0] EV_ADONE = 4'd6;
    localparam logic [3:0] EV_CLEAR = 4'd7;
    localparam logic [3:0] EV_OK    = 4'd8;
    localparam logic [3:0] EV_ERR   = 4'd9;

    // Markup characters
    localparam logic [7:0] CH_LT    = 8'h3C;  // <
    localparam logic [7:0] CH_SLASH = 8'h2F;  // /
    localparam logic [7:0] CH_GT    = 8'h3E;  // >
    localparam logic [7:0] CH_EQ    = 8'h3D;  // =
    localparam logic [7:0] CH_BANG  = 8'h21;  // !
    localparam logic [7:0] CH_QUEST = 8'h3F;  // ?
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_QUOTE = 8'h22;  // "
    localparam logic [7:0] CH_NUL   = 8'h00;

    // One token event as seen by the consumer
    typedef struct packed {
        logic [3:0]         code;
        logic [7:0]         chr;
        logic [DEPTH_W-1:0] depth;
        logic               clr;
    } ev_t;

    // Scanner result for one byte: one or two events
    typedef struct packed {
        logic two;
        ev_t  ev0;
        ev_t  ev1;
    } entry_t;

endpackage

// ----- sv/xst_front.sv -----
`include "xml_stream_tokenizer_assert.svh"

module xst_front #(
    parameter int MAX_DEPTH = 32
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_fire,
    input  logic [7:0]        ch,
    output logic              ev_valid,
    output xst_pkg::entry_t   ev_entry
);

    localparam int DW = $clog2(MAX_DEPTH + 1);
    localparam int OW = xst_pkg::DEPTH_W;

    typedef enum logic [3:0] {
        S_TEXT, S_NAME, S_ENDING, S_NEWNAME, S_TAG, S_ATTRNAME,
        S_AFTERATTR, S_ATTRVAL, S_EXITSINGLE, S_SKIP, S_ERROR
    } state_t;

    typedef struct packed {
        logic          hit;
        state_t        st;
        logic [DW-1:0] d;
        xst_pkg::ev_t  ev;
    } tag_res_t;

    state_t        state_reg, state_next;
    logic [DW-1:0] depth_reg, depth_next;
    logic          two;
    logic          any;
    xst_pkg::ev_t  ev0, ev1;
    tag_res_t      tr;

    function automatic logic word_char(input logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) ||
               (c == 8'h5F) || (c >= 8'h30 && c <= 8'h39);
    endfunction

    function automatic xst_pkg::ev_t mk_ev(input logic [3:0] code, input logic [7:0] c,
                                           input logic [DW-1:0] d, input logic clr);
        xst_pkg::ev_t e;
        e.code  = code;
        e.chr   = c;
        e.depth = OW'(d);
        e.clr   = clr;
        return e;
    endfunction

    // Byte inside a start tag, between attributes
    function automatic tag_res_t tag_step(input logic [7:0] c, input logic [DW-1:0] d);
        tag_res_t r;
        r.hit = 1'b1;
        r.st  = S_TAG;
        r.d   = d;
        r.ev  = mk_ev(xst_pkg::EV_TEXT, 8'h00, d, 1'b0);
        if (c == xst_pkg::CH_SLASH) begin
            if (d == '0) begin
                r.st = S_ERROR;
                r.ev = mk_ev(xst_pkg::EV_ERR, 8'h00, d, 1'b0);
            end else begin
                r.d  = d - DW'(1);
                r.st = S_EXITSINGLE;
                r.ev = mk_ev(xst_pkg::EV_CLOSE, 8'h00, d - DW'(1), 1'b1);
            end
        end else if (c == xst_pkg::CH_GT) begin
            r.st = S_TEXT;
            r.ev = mk_ev(xst_pkg::EV_CLEAR, 8'h00, d, 1'b1);
        end else if (word_char(c)) begin
            r.st = S_ATTRNAME;
            r.ev = mk_ev(xst_pkg::EV_ANAME, c, d, 1'b0);
        end else begin
            r.hit = 1'b0;
        end
        return r;
    endfunction

    // Scanner next state and events for the byte on the input
    always_comb
    begin
        state_next = state_reg;
        depth_next = depth_reg;
        any        = 1'b0;
        two        = 1'b0;
        ev0        = '0;
        ev1        = '0;
        tr         = tag_step(ch, depth_reg);
        if (ch == xst_pkg::CH_NUL) begin
            // end of document: verdict unless already in error, then back to reset state
            state_next = S_TEXT;
            depth_next = '0;
            if (state_reg == S_TEXT && depth_reg == '0) begin
                any = 1'b1;
                ev0 = mk_ev(xst_pkg::EV_OK, 8'h00, '0, 1'b0);
            end else if (state_reg != S_ERROR) begin
                any = 1'b1;
                ev0 = mk_ev(xst_pkg::EV_ERR, 8'h00, '0, 1'b0);
            end
        end else begin
            unique case (state_reg) inside
                S_TEXT:
                begin
                    if (ch == xst_pkg::CH_LT) begin
                        state_next = S_NAME;
                    end else begin
                        any = 1'b1;
                        ev0 = mk_ev(xst_pkg::EV_TEXT, ch, depth_reg, 1'b0);
                    end
                end
                S_NAME:
                begin
                    if (ch == xst_pkg::CH_SLASH) begin
                        if (depth_reg == '0) begin
                            state_next = S_ERROR;
                            any        = 1'b1;
                            ev0        = mk_ev(xst_pkg::EV_ERR, 8'h00, depth_reg, 1'b0);
                        end else begin
                            state_next = S_ENDING;
                        end
                    end else if (ch == xst_pkg::CH_BANG || ch == xst_pkg::CH_QUEST) begin
                        state_next = S_SKIP;
                    end else if (word_char(ch)) begin
                        state_next = S_NEWNAME;
                        any        = 1'b1;
                        ev0        = mk_ev(xst_pkg::EV_NAME, ch, depth_reg, 1'b0);
                    end
                end
                S_ENDING:
                begin
                    // end-tag name is skipped unchecked
                    if (ch == xst_pkg::CH_GT) begin
                        depth_next = depth_reg - DW'(1);
                        state_next = S_TEXT;
                        any        = 1'b1;
                        ev0        = mk_ev(xst_pkg::EV_CLOSE, 8'h00,
                                           depth_reg - DW'(1), 1'b1);
                    end
                end
                S_NEWNAME:
                begin
                    if (ch == xst_pkg::CH_SLASH || ch == xst_pkg::CH_SPACE ||
                        ch == xst_pkg::CH_GT) begin
                        any = 1'b1;
                        if (depth_reg >= DW'(MAX_DEPTH)) begin
                            state_next = S_ERROR;
                            ev0        = mk_ev(xst_pkg::EV_ERR, 8'h00, depth_reg, 1'b0);
                        end else if (ch == xst_pkg::CH_GT) begin
                            depth_next = depth_reg + DW'(1);
                            state_next = S_TEXT;
                            ev0        = mk_ev(xst_pkg::EV_OPEN, 8'h00,
                                               depth_reg + DW'(1), 1'b1);
                        end else if (ch == xst_pkg::CH_SLASH) begin
                            // self-closing: open then close on the same byte
                            two        = 1'b1;
                            state_next = S_EXITSINGLE;
                            ev0        = mk_ev(xst_pkg::EV_OPEN, 8'h00,
                                               depth_reg + DW'(1), 1'b0);
                            ev1        = mk_ev(xst_pkg::EV_CLOSE, 8'h00, depth_reg, 1'b1);
                        end else begin
                            depth_next = depth_reg + DW'(1);
                            state_next = S_TAG;
                            ev0        = mk_ev(xst_pkg::EV_OPEN, 8'h00,
                                               depth_reg + DW'(1), 1'b0);
                        end
                    end else begin
                        any = 1'b1;
                        ev0 = mk_ev(xst_pkg::EV_NAME, ch, depth_reg, 1'b0);
                    end
                end
                S_TAG:
                begin
                    state_next = tr.st;
                    depth_next = tr.d;
                    any        = tr.hit;
                    ev0        = tr.ev;
                end
                S_ATTRNAME:
                begin
                    if (ch == xst_pkg::CH_EQ) begin
                        state_next = S_AFTERATTR;
                    end else begin
                        any = 1'b1;
                        ev0 = mk_ev(xst_pkg::EV_ANAME, ch, depth_reg, 1'b0);
                    end
                end
                S_AFTERATTR:
                begin
                    if (ch == xst_pkg::CH_QUOTE) begin
                        state_next = S_ATTRVAL;
                    end else begin
                        // unquoted value: attribute done, byte rescanned as tag content
                        any        = 1'b1;
                        ev0        = mk_ev(xst_pkg::EV_ADONE, 8'h00, depth_reg, 1'b0);
                        two        = tr.hit;
                        ev1        = tr.ev;
                        state_next = tr.st;
                        depth_next = tr.d;
                    end
                end
                S_ATTRVAL:
                begin
                    any = 1'b1;
                    if (ch == xst_pkg::CH_QUOTE) begin
                        state_next = S_TAG;
                        ev0        = mk_ev(xst_pkg::EV_ADONE, 8'h00, depth_reg, 1'b0);
                    end else begin
                        ev0 = mk_ev(xst_pkg::EV_AVAL, ch, depth_reg, 1'b0);
                    end
                end
                S_EXITSINGLE, S_SKIP:
                begin
                    if (ch == xst_pkg::CH_GT) begin
                        state_next = S_TEXT;
                        any        = 1'b1;
                        ev0        = mk_ev(xst_pkg::EV_CLEAR, 8'h00, depth_reg, 1'b1);
                    end
                end
                default:
                begin
                    state_next = S_ERROR;
                end
            endcase
        end
    end

    assign ev_valid     = in_fire && any;
    assign ev_entry.two = two;
    assign ev_entry.ev0 = ev0;
    assign ev_entry.ev1 = ev1;

    // Scanner state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= S_TEXT;
            depth_reg <= '0;
        end else if (in_fire) begin
            state_reg <= state_next;
            depth_reg <= depth_next;
        end
    end

    `XST_ASSERT(a_depth_bound, clk, rst_n, depth_reg <= DW'(MAX_DEPTH))
    `XST_ASSERT_NEVER(a_err_quiet, clk, rst_n, ev_valid && state_reg == S_ERROR && (|ch))

endmodule

// ----- sv/xst_queue.sv -----
`include "xml_stream_tokenizer_assert.svh"

module xst_queue #(
    parameter int DEPTH = 4
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  xst_pkg::entry_t push_data,
    output logic            full,
    input  logic            pop,
    output logic            q_valid,
    output xst_pkg::entry_t q_data
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    xst_pkg::entry_t mem_reg [DEPTH];
    logic [PW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]   count_reg, count_next;

    assign full    = (count_reg == CW'(DEPTH));
    assign q_valid = (count_reg != '0);
    assign q_data  = mem_reg[rd_ptr_reg];

    // Pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (push && !pop) begin
            count_next = count_reg + CW'(1);
        end else if (pop && !push) begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage, no reset needed
    always_ff @(posedge clk)
    begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    `XST_ASSERT(a_count_bound, clk, rst_n, count_reg <= CW'(DEPTH))
    `XST_ASSERT_NEVER(a_pop_empty, clk, rst_n, pop && count_reg == '0)

endmodule

// ----- sv/xst_back.sv -----
`include "xml_stream_tokenizer_assert.svh"

module xst_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          q_valid,
    input  xst_pkg::entry_t               q_data,
    output logic                          pop,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [3:0]                    event_res,
    output logic [7:0]                    char_out,
    output logic [xst_pkg::DEPTH_W-1:0]   depth,
    output logic                          clear_text,
    output logic                          last
);

    logic         out_valid_reg, out_valid_next;
    xst_pkg::ev_t out_ev_reg, out_ev_next;
    logic         last_reg, last_next;
    logic         pend_valid_reg, pend_valid_next;
    xst_pkg::ev_t pend_ev_reg, pend_ev_next;
    logic         out_free;

    // Output register is free when empty or being taken
    assign out_free = !out_valid_reg || out_ready;
    assign pop      = out_free && !pend_valid_reg && q_valid;

    // Serialize one or two events per entry
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_ev_next     = out_ev_reg;
        last_next       = last_reg;
        pend_valid_next = pend_valid_reg;
        pend_ev_next    = pend_ev_reg;
        if (out_free) begin
            if (pend_valid_reg) begin
                out_valid_next  = 1'b1;
                out_ev_next     = pend_ev_reg;
                last_next       = 1'b1;
                pend_valid_next = 1'b0;
            end else if (q_valid) begin
                out_valid_next  = 1'b1;
                out_ev_next     = q_data.ev0;
                last_next       = !q_data.two;
                pend_valid_next = q_data.two;
                pend_ev_next    = q_data.ev1;
            end else begin
                out_valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        out_ev_reg  <= out_ev_next;
        last_reg    <= last_next;
        pend_ev_reg <= pend_ev_next;
    end

    assign out_valid  = out_valid_reg;
    assign event_res  = out_ev_reg.code;
    assign char_out   = out_ev_reg.chr;
    assign depth      = out_ev_reg.depth;
    assign clear_text = out_ev_reg.clr;
    assign last       = last_reg;

    `XST_ASSERT(a_pend_has_first, clk, rst_n, !pend_valid_reg || (out_valid_reg && !last_reg))

endmodule

// ----- sv/xml_stream_tokenizer.sv -----
// Channel  | Handshake             | Payload
// ---------+-----------------------+------------------------------------------------
// input    | in_valid / in_ready   | ch
// output   | out_valid / out_ready | event_res, char_out, depth, clear_text, last
//
// One byte is accepted per cycle; the scanner settles state and events in that cycle.
// Output carries one event per cycle while out_ready is high; a byte with two events
// uses the back end twice. Events pass the event queue, then the output register.
// in_ready drops only when the QUEUE_DEPTH event queue is full.
// Reset (rst_n low) returns to the text state at depth zero and empties the queue.

`include "xml_stream_tokenizer_assert.svh"

module xml_stream_tokenizer #(
    parameter int MAX_DEPTH   = 32,
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [7:0]                    ch,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [3:0]                    event_res,
    output logic [7:0]                    char_out,
    output logic [xst_pkg::DEPTH_W-1:0]   depth,
    output logic                          clear_text,
    output logic                          last
);

    logic            in_fire;
    logic            ev_valid;
    xst_pkg::entry_t ev_entry;
    logic            q_full;
    logic            q_valid;
    logic            q_pop;
    xst_pkg::entry_t q_data;

    assign in_ready = !q_full;
    assign in_fire  = in_valid && in_ready;

    // Scanner front end
    xst_front #(
        .MAX_DEPTH (MAX_DEPTH)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_fire  (in_fire),
        .ch       (ch),
        .ev_valid (ev_valid),
        .ev_entry (ev_entry)
    );

    // Event queue
    xst_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (ev_valid),
        .push_data (ev_entry),
        .full      (q_full),
        .pop       (q_pop),
        .q_valid   (q_valid),
        .q_data    (q_data)
    );

    // Event serializer and output register
    xst_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_valid    (q_valid),
        .q_data     (q_data),
        .pop        (q_pop),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .event_res  (event_res),
        .char_out   (char_out),
        .depth      (depth),
        .clear_text (clear_text),
        .last       (last)
    );

    `XST_ASSERT_NEVER(a_push_full, clk, rst_n, ev_valid && q_full)

endmodule

// ----- tb/xml_stream_tokenizer_test.sv -----
`timescale 1ns / 1ps

module xml_stream_tokenizer_test;

    localparam int DEPTH_W     = xst_pkg::DEPTH_W;
    localparam int MAX_DEPTH   = 32;
    localparam int STALL_LIMIT = 5000;
    localparam int DRAIN_WAIT  = 20;

    // Scanner states of the tokenizer
    typedef enum logic [3:0] {
        ST_TEXT,
        ST_NAME,
        ST_ENDING,
        ST_NEWNAME,
        ST_TAG,
        ST_ATTRNAME,
        ST_AFTERATTR,
        ST_ATTRVAL,
        ST_EXITSINGLE,
        ST_SKIP,
        ST_ERROR
    } scan_state_e;

    // One token event as it leaves the block
    typedef struct packed {
        logic [3:0]         code;
        logic [7:0]         chr;
        logic [DEPTH_W-1:0] nest_lvl;
        logic               clr;
        logic               last;
    } token_t;

    logic               clk        = 1'b0;
    logic               rst_n      = 1'b0;
    logic               in_valid   = 1'b0;
    logic               in_ready;
    logic [7:0]         ch         = 8'h00;
    logic               out_valid;
    logic               out_ready  = 1'b0;
    logic [3:0]         event_res;
    logic [7:0]         char_out;
    logic [DEPTH_W-1:0] depth;
    logic               clear_text;
    logic               last;

    logic [7:0]  doc_bytes [$];   // bytes waiting to be driven
    token_t      token_q   [$];   // tokens predicted, not yet seen
    scan_state_e scan_st   = ST_TEXT;
    int          nest      = 0;
    int          n_in      = 0;
    int          n_fail    = 0;
    int          stall_cycles = 0;
    int          seg_start [3];
    logic        in_fire   = 1'b0;

    xml_stream_tokenizer #(
        .MAX_DEPTH (MAX_DEPTH)
    ) i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .ch         (ch),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .event_res  (event_res),
        .char_out   (char_out),
        .depth      (depth),
        .clear_text (clear_text),
        .last       (last)
    );

    always #2 clk = ~clk;

    // ---------------------------------------------------------------
    // Tokenizer prediction
    // ---------------------------------------------------------------

    // Letters, digits and underscore
    function automatic bit is_name_char(input logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) ||
               (c >= 8'h30 && c <= 8'h39) || c == 8'h5F;
    endfunction

    function automatic void push_token(input logic [3:0] code, input logic [7:0] chr,
                                       input logic clr);
        token_q.push_back('{code, chr, DEPTH_W'(nest), clr, 1'b0});
    endfunction

    function automatic void latch_error();
        scan_st = ST_ERROR;
        push_token(xst_pkg::EV_ERR, 8'h00, 1'b0);
    endfunction

    // Byte seen inside a start tag
    function automatic void scan_tag(input logic [7:0] c);
        if (c == xst_pkg::CH_SLASH) begin
            if (nest == 0)
                latch_error();
            else
            begin
                nest--;
                scan_st = ST_EXITSINGLE;
                push_token(xst_pkg::EV_CLOSE, 8'h00, 1'b1);
            end
        end
        else if (c == xst_pkg::CH_GT)
        begin
            scan_st = ST_TEXT;
            push_token(xst_pkg::EV_CLEAR, 8'h00, 1'b1);
        end
        else if (is_name_char(c))
        begin
            scan_st = ST_ATTRNAME;
            push_token(xst_pkg::EV_ANAME, c, 1'b0);
        end
    endfunction

    // Advance the scanner by one byte and queue the tokens it emits
    function automatic void tokenize_byte(input logic [7:0] c);
        int     n_prior;
        token_t t;
        n_prior = token_q.size();
        if (c == xst_pkg::CH_NUL)
        begin
            if (scan_st == ST_TEXT && nest == 0)
                push_token(xst_pkg::EV_OK, 8'h00, 1'b0);
            else if (scan_st != ST_ERROR)
            begin
                nest = 0;
                push_token(xst_pkg::EV_ERR, 8'h00, 1'b0);
            end
            scan_st = ST_TEXT;
            nest    = 0;
        end
        else
        begin
            case (scan_st) inside
                ST_TEXT:
                    if (c == xst_pkg::CH_LT)
                        scan_st = ST_NAME;
                    else
                        push_token(xst_pkg::EV_TEXT, c, 1'b0);
                ST_NAME:
                    if (c == xst_pkg::CH_SLASH)
                    begin
                        if (nest == 0)
                            latch_error();
                        else
                            scan_st = ST_ENDING;
                    end
                    else if (c == xst_pkg::CH_BANG || c == xst_pkg::CH_QUEST)
                        scan_st = ST_SKIP;
                    else if (is_name_char(c))
                    begin
                        scan_st = ST_NEWNAME;
                        push_token(xst_pkg::EV_NAME, c, 1'b0);
                    end
                ST_ENDING:
                    // end-tag name is not matched against the open element
                    if (c == xst_pkg::CH_GT)
                    begin
                        nest--;
                        scan_st = ST_TEXT;
                        push_token(xst_pkg::EV_CLOSE, 8'h00, 1'b1);
                    end
                ST_NEWNAME:
                    if (c == xst_pkg::CH_SLASH || c == xst_pkg::CH_SPACE ||
                        c == xst_pkg::CH_GT)
                    begin
                        if (nest >= MAX_DEPTH)
                            latch_error();
                        else
                        begin
                            nest++;
                            if (c == xst_pkg::CH_GT)
                            begin
                                scan_st = ST_TEXT;
                                push_token(xst_pkg::EV_OPEN, 8'h00, 1'b1);
                            end
                            else
                            begin
                                scan_st = ST_TAG;
                                push_token(xst_pkg::EV_OPEN, 8'h00, 1'b0);
                                // self-closing: the same slash also closes
                                if (c == xst_pkg::CH_SLASH)
                                    scan_tag(c);
                            end
                        end
                    end
                    else
                        push_token(xst_pkg::EV_NAME, c, 1'b0);
                ST_TAG:
                    scan_tag(c);
                ST_ATTRNAME:
                    if (c == xst_pkg::CH_EQ)
                        scan_st = ST_AFTERATTR;
                    else
                        push_token(xst_pkg::EV_ANAME, c, 1'b0);
                ST_AFTERATTR:
                    if (c == xst_pkg::CH_QUOTE)
                        scan_st = ST_ATTRVAL;
                    else
                    begin
                        // unquoted value: done, then rescan the byte as tag content
                        scan_st = ST_TAG;
                        push_token(xst_pkg::EV_ADONE, 8'h00, 1'b0);
                        scan_tag(c);
                    end
                ST_ATTRVAL:
                    if (c == xst_pkg::CH_QUOTE)
                    begin
                        scan_st = ST_TAG;
                        push_token(xst_pkg::EV_ADONE, 8'h00, 1'b0);
                    end
                    else
                        push_token(xst_pkg::EV_AVAL, c, 1'b0);
                ST_EXITSINGLE, ST_SKIP:
                    if (c == xst_pkg::CH_GT)
                    begin
                        scan_st = ST_TEXT;
                        push_token(xst_pkg::EV_CLEAR, 8'h00, 1'b1);
                    end
                default:
                    scan_st = ST_ERROR;
            endcase
        end
        if (token_q.size() > n_prior)
        begin
            t = token_q.pop_back();
            t.last = 1'b1;
            token_q.push_back(t);
        end
    endfunction

    // ---------------------------------------------------------------
    // Document generation
    // ---------------------------------------------------------------

    function automatic logic [7:0] any_but(input logic [7:0] x);
        logic [7:0] c;
        do
            c = 8'($urandom_range(1, 255));
        while (c == x);
        return c;
    endfunction

    function automatic logic [7:0] name_char();
        case ($urandom_range(3))
            0:       return 8'h61 + 8'($urandom_range(25));  // a-z
            1:       return 8'h41 + 8'($urandom_range(25));  // A-Z
            2:       return 8'h30 + 8'($urandom_range(9));   // 0-9
            default: return 8'h5F;                           // _
        endcase
    endfunction

    function automatic logic [7:0] noise_char();
        case ($urandom_range(15))
            0:       return xst_pkg::CH_LT;
            1:       return xst_pkg::CH_SLASH;
            2:       return xst_pkg::CH_GT;
            3:       return xst_pkg::CH_EQ;
            4:       return xst_pkg::CH_BANG;
            5:       return xst_pkg::CH_QUEST;
            6:       return xst_pkg::CH_SPACE;
            7:       return xst_pkg::CH_QUOTE;
            default: return 8'($urandom_range(1, 255));
        endcase
    endfunction

    function automatic void put_name();
        repeat ($urandom_range(1, 3))
            doc_bytes.push_back(name_char());
    endfunction

    function automatic void push_str(input string s);
        for (int i = 0; i < s.len(); i++)
            doc_bytes.push_back(s[i]);
    endfunction

    // Element with optional attributes, either self-closing or with a body of zero or more children
    function automatic void gen_element(input int lvl);
        int n_attr;
        bit has_body;
        bit ended;
        n_attr   = $urandom_range(2);
        has_body = $urandom_range(2) != 0;
        ended    = 1'b0;
        doc_bytes.push_back(xst_pkg::CH_LT);
        put_name();
        if (n_attr == 0 && $urandom_range(1))
            doc_bytes.push_back(xst_pkg::CH_SPACE);
        for (int i = 0; i < n_attr; i++)
        begin
            doc_bytes.push_back(xst_pkg::CH_SPACE);
            put_name();
            doc_bytes.push_back(xst_pkg::CH_EQ);
            if (i == n_attr - 1 && $urandom_range(3) == 0)
            begin
                // unquoted: the tag end follows the equals sign directly
                if (!has_body)
                    doc_bytes.push_back(xst_pkg::CH_SLASH);
                doc_bytes.push_back(xst_pkg::CH_GT);
                ended = 1'b1;
            end
            else
            begin
                doc_bytes.push_back(xst_pkg::CH_QUOTE);
                repeat ($urandom_range(3))
                    doc_bytes.push_back(any_but(xst_pkg::CH_QUOTE));
                doc_bytes.push_back(xst_pkg::CH_QUOTE);
            end
        end
        if (!ended)
        begin
            if (!has_body)
                doc_bytes.push_back(xst_pkg::CH_SLASH);
            doc_bytes.push_back(xst_pkg::CH_GT);
        end
        if (has_body)
        begin
            repeat ($urandom_range(0, lvl < 3 ? 3 : 0))
                gen_node(lvl + 1);
            doc_bytes.push_back(xst_pkg::CH_LT);
            doc_bytes.push_back(xst_pkg::CH_SLASH);
            if ($urandom_range(3) != 0)
                put_name();
            doc_bytes.push_back(xst_pkg::CH_GT);
        end
    endfunction

    // Text run, comment or processing instruction, or element
    function automatic void gen_node(input int lvl);
        int kind;
        kind = $urandom_range(9);
        if (kind < 3)
            repeat ($urandom_range(1, 4))
                doc_bytes.push_back(any_but(xst_pkg::CH_LT));
        else if (kind == 3)
        begin
            doc_bytes.push_back(xst_pkg::CH_LT);
            doc_bytes.push_back($urandom_range(1) ? xst_pkg::CH_BANG : xst_pkg::CH_QUEST);
            repeat ($urandom_range(3))
                doc_bytes.push_back(any_but(xst_pkg::CH_GT));
            doc_bytes.push_back(xst_pkg::CH_GT);
        end
        else
            gen_element(lvl);
    endfunction

    // Mostly well-formed documents; some cut short, some pure noise
    function automatic void gen_doc();
        int start_n;
        int kind;
        int cut;
        start_n = doc_bytes.size();
        kind    = $urandom_range(19);
        if (kind < 3)
            repeat ($urandom_range(1, 12))
                doc_bytes.push_back(noise_char());
        else
        begin
            repeat ($urandom_range(1, 3))
                gen_node(0);
            if (kind < 6 && doc_bytes.size() > start_n + 1)
            begin
                cut = $urandom_range(start_n + 1, doc_bytes.size() - 1);
                while (doc_bytes.size() > cut)
                    void'(doc_bytes.pop_back());
            end
        end
        doc_bytes.push_back(xst_pkg::CH_NUL);
    endfunction

    // Deep nesting near the depth limit; past it the error latches
    function automatic void deep_doc(input int n_open);
        int n_close;
        if (n_open > MAX_DEPTH)
            n_close = 0;
        else
            n_close = $urandom_range(1) ? n_open : $urandom_range(n_open);
        repeat (n_open)
        begin
            doc_bytes.push_back(xst_pkg::CH_LT);
            doc_bytes.push_back(name_char());
            doc_bytes.push_back(xst_pkg::CH_GT);
        end
        repeat (n_close)
            push_str("</>");
        doc_bytes.push_back(xst_pkg::CH_NUL);
    endfunction

    // ---------------------------------------------------------------
    // Driver: inputs change on the falling edge
    // ---------------------------------------------------------------
    always @(negedge clk)
    begin
        int send_gap;
        int recv_gap;
        if (rst_n)
        begin
            if (n_in < seg_start[1])
            begin
                send_gap = 14;
                recv_gap = 64;
            end
            else if (n_in < seg_start[2])
            begin
                send_gap = 64;
                recv_gap = 14;
            end
            else
            begin
                send_gap = 0;
                recv_gap = 0;
            end
            // hold the byte until its transaction completes
            if (!in_valid || in_fire)
            begin
                if (doc_bytes.size() != 0 && $urandom_range(99) >= send_gap)
                begin
                    ch       <= doc_bytes.pop_front();
                    in_valid <= 1'b1;
                end
                else
                    in_valid <= 1'b0;
            end
            out_ready <= $urandom_range(99) >= recv_gap;
        end
    end

    // ---------------------------------------------------------------
    // Monitor and checker: sampled on the rising edge
    // ---------------------------------------------------------------
    always @(posedge clk)
    begin
        token_t got;
        token_t want;
        if (rst_n)
        begin
            in_fire <= in_valid && in_ready;

            // check the outgoing transaction before predicting new ones
            if (out_valid && out_ready)
            begin
                got = '{event_res, char_out, depth, clear_text, last};
                if (token_q.size() == 0)
                begin
                    $display({"%0t: unexpected token ",
                              "code=%0d chr=%02h depth=%0d clr=%0b last=%0b"},
                             $time, got.code, got.chr, got.nest_lvl, got.clr, got.last);
                    n_fail++;
                end
                else
                begin
                    want = token_q.pop_front();
                    if (got != want)
                    begin
                        $display({"%0t: token mismatch: expected ",
                                  "code=%0d chr=%02h depth=%0d clr=%0b last=%0b"},
                                 $time, want.code, want.chr, want.nest_lvl, want.clr,
                                 want.last);
                        $display({"%0t:                 actual   ",
                                  "code=%0d chr=%02h depth=%0d clr=%0b last=%0b"},
                                 $time, got.code, got.chr, got.nest_lvl, got.clr,
                                 got.last);
                        n_fail++;
                    end
                end
            end

            if (in_valid && in_ready)
            begin
                tokenize_byte(ch);
                n_in++;
            end

            // watchdog on cycles without any transaction
            if ((in_valid && in_ready) || (out_valid && out_ready))
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("xml_stream_tokenizer regression: fail");
                $finish;
            end
        end
    end

    // ---------------------------------------------------------------
    // Stimulus and end of run
    // ---------------------------------------------------------------
    initial
    begin
        // directed: extreme text bytes, top-level close with latched error,
        // self-closing element, unquoted attribute ending the tag, skipped tag
        seg_start[0] = 0;
        doc_bytes.push_back(xst_pkg::CH_NUL);
        doc_bytes.push_back(8'hFF);
        doc_bytes.push_back(8'h01);
        doc_bytes.push_back(xst_pkg::CH_NUL);
        push_str("</x");
        doc_bytes.push_back(xst_pkg::CH_NUL);
        push_str("<a/>");
        doc_bytes.push_back(xst_pkg::CH_NUL);
        push_str("<b c=/>");
        doc_bytes.push_back(xst_pkg::CH_NUL);
        push_str("<?>");
        doc_bytes.push_back(xst_pkg::CH_NUL);

        // random documents in three phases of idling: mostly the sink, mostly the source, none
        for (int seg = 0; seg < 3; seg++)
        begin
            if (seg > 0)
                seg_start[seg] = doc_bytes.size();
            deep_doc(seg == 0 ? MAX_DEPTH + 1 : $urandom_range(MAX_DEPTH - 4, MAX_DEPTH + 2));
            while (doc_bytes.size() < 25 + 267 * (seg + 1))
                gen_doc();
        end

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (doc_bytes.size() != 0 || in_valid)
            @(posedge clk);
        while (token_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        if (n_fail == 0)
            $display("xml_stream_tokenizer regression: pass");
        else
            $display("xml_stream_tokenizer regression: fail");
        $finish;
    end

endmodule
